FILE: hw/rtl/mt64cg_pkg.sv
// shared constants, types and command codes for the mt64 chunk generator
`default_nettype none
package mt64cg_pkg;

  localparam int TW_N  = 312;
  localparam int TW_M  = 156;
  localparam int POS_W = $clog2(TW_N);

  localparam logic [63:0] TW_MATRIX   = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TW_UPPER    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] TW_LOWER    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] TW_INIT_MUL = 64'd6364136223846793005;

  localparam int DEF_MAX_CHUNK_BYTES = 65536;

  localparam int BYTES_W     = 17;
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 72;

  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // command codes, also used as the queued operation kind
  typedef enum logic {
    OP_START = 1'b0,
    OP_DRAW  = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [63:0] seed;
    logic [3:0]  take;
    logic        last;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mt64cg_queue.sv
// short operation queue between the command front end and the twister engine
`default_nettype none
module mt64cg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mt64cg_pkg::op_t       push_op,
  input  logic                  pop,
  output mt64cg_pkg::op_t       head_op,
  output mt64cg_pkg::q_status_t status
);
  import mt64cg_pkg::*;

  op_t                entries [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr;
  logic [Q_IDX_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head_op      = entries[rd_ptr];
  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mt64cg_front.sv
// command front end: byte accounting, seed sum and operation issue
`default_nettype none
module mt64cg_front #(
  parameter int MAX_CHUNK_BYTES = mt64cg_pkg::DEF_MAX_CHUNK_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mt64cg_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                              s_tuser,
  input  mt64cg_pkg::q_status_t             q_status,
  output logic                              push,
  output mt64cg_pkg::op_t                   push_op
);
  import mt64cg_pkg::*;

  localparam logic [31:0] MaxBytes32 = 32'(MAX_CHUNK_BYTES);

  logic [BYTES_W-1:0] bytes_left;
  logic [BYTES_W-1:0] bytes_left_next;
  logic [63:0]        owner_id;
  logic [63:0]        chunk_seq;
  logic [BYTES_W-1:0] chunk_bytes;
  logic [BYTES_W-1:0] chunk_sat;
  logic [3:0]         take;
  logic               accept;
  op_kind_t           kind;

  assign owner_id    = s_tdata[63:0];
  assign chunk_seq   = s_tdata[127:64];
  assign chunk_bytes = s_tdata[144:128];
  assign kind        = op_kind_t'(s_tuser);

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  assign chunk_sat = ({15'd0, chunk_bytes} > MaxBytes32) ? MaxBytes32[BYTES_W-1:0]
                                                          : chunk_bytes;
  assign take = (bytes_left < BYTES_W'(8)) ? bytes_left[3:0] : 4'd8;
  assign bytes_left_next = bytes_left - BYTES_W'(take);

  // a draw with nothing left in the chunk is swallowed here
  assign push = accept && ((kind == OP_START) || (bytes_left != '0));

  always_comb begin
    push_op.kind = kind;
    push_op.seed = owner_id + chunk_seq;
    push_op.take = take;
    push_op.last = (bytes_left_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
    end else if (accept) begin
      if (kind == OP_START) begin
        bytes_left <= chunk_sat;
      end else if (bytes_left != '0) begin
        bytes_left <= bytes_left_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mt64cg_back.sv
// twister engine: seeding sweep, one-entry twist per draw, tempering, output register
`default_nettype none
module mt64cg_back (
  input  logic                               clk,
  input  logic                               rst,
  input  mt64cg_pkg::op_t                    head_op,
  input  mt64cg_pkg::q_status_t              q_status,
  output logic                               pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mt64cg_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                               m_tlast
);
  import mt64cg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SV, ST_MA, ST_MB, ST_MC, ST_SADD, ST_RJ, ST_RK, ST_WR, ST_OUT
  } state_t;

  state_t           state;
  logic [63:0]      mem [TW_N];
  logic [63:0]      rd_data;
  logic [POS_W-1:0] rd_addr;
  logic             we;
  logic [POS_W-1:0] wr_addr;
  logic [63:0]      wr_data;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] j;
  logic [POS_W-1:0] k;
  logic [63:0]      cur;
  logic [63:0]      hold_j;
  logic [63:0]      prev;
  logic [63:0]      vreg;
  logic [63:0]      acc;
  logic [31:0]      hi;
  logic [63:0]      tw_new;
  logic [3:0]       op_take;
  logic             op_last;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] seed_word;
  logic [63:0] x;
  logic [63:0] xa;
  logic [63:0] twisted;
  logic        out_load;

  function automatic logic [63:0] temper(input logic [63:0] y_in);
    logic [63:0] y;
    y = y_in;
    y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
    y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
    y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
    y = y ^ (y >> 43);
    return y;
  endfunction

  assign j = (pos == POS_W'(TW_N - 1)) ? '0 : pos + 1'b1;
  assign k = (pos < POS_W'(TW_M)) ? pos + POS_W'(TW_M) : pos - POS_W'(TW_M);

  // low 64 bits of the init multiply from three 32x32 partial products
  assign mul_a = (state == ST_MB) ? TW_INIT_MUL[63:32] : TW_INIT_MUL[31:0];
  assign mul_b = (state == ST_MC) ? vreg[63:32] : vreg[31:0];
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
  assign seed_word = {hi, acc[31:0]} + {{(64-POS_W){1'b0}}, idx};

  assign x       = (cur & TW_UPPER) | (hold_j & TW_LOWER);
  assign xa      = x[0] ? ((x >> 1) ^ TW_MATRIX) : (x >> 1);
  assign twisted = rd_data ^ xa;

  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign rd_addr  = (state == ST_RJ) ? j : k;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    we      = 1'b0;
    wr_addr = pos;
    wr_data = twisted;
    if (pop && head_op.kind == OP_START) begin
      we      = 1'b1;
      wr_addr = '0;
      wr_data = head_op.seed;
    end else if (state == ST_SADD) begin
      we      = 1'b1;
      wr_addr = idx;
      wr_data = seed_word;
    end else if (state == ST_WR) begin
      we      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head_op.kind == OP_START) begin
              prev  <= head_op.seed;
              cur   <= head_op.seed;
              pos   <= '0;
              idx   <= POS_W'(1);
              state <= ST_SV;
            end else begin
              op_take <= head_op.take;
              op_last <= head_op.last;
              state   <= ST_RJ;
            end
          end
        end
        ST_SV: begin
          vreg  <= prev ^ (prev >> 62);
          state <= ST_MA;
        end
        ST_MA: begin
          acc   <= prod;
          state <= ST_MB;
        end
        ST_MB: begin
          hi    <= acc[63:32] + prod[31:0];
          state <= ST_MC;
        end
        ST_MC: begin
          hi    <= hi + prod[31:0];
          state <= ST_SADD;
        end
        ST_SADD: begin
          prev <= seed_word;
          if (idx == POS_W'(TW_N - 1)) begin
            state <= ST_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_SV;
          end
        end
        ST_RJ: begin
          state <= ST_RK;
        end
        ST_RK: begin
          hold_j <= rd_data;
          state  <= ST_WR;
        end
        ST_WR: begin
          tw_new <= twisted;
          cur    <= hold_j;
          pos    <= j;
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, op_take, temper(tw_new)};
            m_tlast  <= op_last;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < POS_W'(TW_N))
    else $error("word position out of range");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_IDLE || state == ST_SADD || state == ST_WR))
    else $error("table write outside seeding or twist");

  a_out_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result raised without a finished draw");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != ST_IDLE))
    else $error("engine stayed idle after taking an operation");

endmodule
`default_nettype wire

FILE: hw/rtl/mt64_chunk_generator.sv
// top level of the mt64 chunk generator: front end, queue and twister engine
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser command, s_tdata id/index/bytes
//  m_*      out  m_tvalid/m_tready  m_tdata word/valid bytes, m_tlast end of chunk
//
// a draw passes through the engine in order: two reads of the single-read
// word table port, a write back, then the output register.
// a start seeds all 312 table words, each word after the first through SV, MA, MB,
// MC and SADD on the shared 32x32 multiplier; the next draw waits for the whole sweep.
// rst is synchronous; table contents are not cleared, the start command writes them.
// a stalled output holds the engine only; the front keeps taking commands until
// the queue fills.
`default_nettype none
module mt64_chunk_generator #(
  parameter int MAX_CHUNK_BYTES = mt64cg_pkg::DEF_MAX_CHUNK_BYTES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // owner_id [63:0], chunk_seq [127:64], chunk_bytes [144:128], zero pad
  input  logic [mt64cg_pkg::IN_TDATA_W-1:0]  s_tdata,
  // command [0]
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // random_word [63:0], valid_bytes [67:64], zero pad
  output logic [mt64cg_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                               m_tlast
);
  import mt64cg_pkg::*;

  logic      push;
  logic      pop;
  op_t       push_op;
  op_t       head_op;
  q_status_t q_status;

  mt64cg_front #(
    .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_status (q_status),
    .push     (push),
    .push_op  (push_op)
  );

  mt64cg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  mt64cg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_op  (head_op),
    .q_status (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

FILE: bench/tb_mt64_chunk_generator.sv
// self-checking testbench for the mt64 chunk generator stream block
`timescale 1ns / 1ps
`default_nettype none
module tb_mt64_chunk_generator;
  import mt64cg_pkg::*;

  localparam int MAX_BYTES = DEF_MAX_CHUNK_BYTES;
  localparam int N_ITEMS   = 1400;

  typedef struct {
    op_kind_t    cmd;
    logic [63:0] owner_id;
    logic [63:0] chunk_seq;
    logic [16:0] chunk_bytes;
  } chunk_cmd_t;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } chunk_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  mt64_chunk_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generator copy kept by the bench
  logic [63:0] mt_state [TW_N];
  int unsigned mt_pos;
  int unsigned mt_left;

  chunk_cmd_t  pending_cmds[$];
  chunk_word_t expected_words[$];
  int n_errors = 0;
  int n_accepted = 0;
  int n_words = 0;
  int n_starts = 0;

  task automatic apply_cmd(input chunk_cmd_t c);
    logic [63:0] p, x, xa, y;
    int unsigned j, k, take;
    chunk_word_t r;
    if (c.cmd == OP_START) begin
      mt_state[0] = c.owner_id + c.chunk_seq;
      for (int i = 1; i < TW_N; i++) begin
        p = mt_state[i-1];
        mt_state[i] = TW_INIT_MUL * (p ^ (p >> 62)) + 64'(i);
      end
      mt_pos = 0;
      mt_left = (c.chunk_bytes > MAX_BYTES) ? MAX_BYTES : c.chunk_bytes;
      n_starts++;
    end else if (mt_left != 0) begin
      j = (mt_pos + 1) % TW_N;
      k = (mt_pos + TW_M) % TW_N;
      x = (mt_state[mt_pos] & TW_UPPER) | (mt_state[j] & TW_LOWER);
      xa = x >> 1;
      if (x[0]) xa = xa ^ TW_MATRIX;
      mt_state[mt_pos] = mt_state[k] ^ xa;
      y = mt_state[mt_pos];
      mt_pos = j;
      y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
      y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
      y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
      y = y ^ (y >> 43);
      take = (mt_left < 8) ? mt_left : 8;
      mt_left -= take;
      r.word = y;
      r.nbytes = 4'(take);
      r.last = (mt_left == 0);
      expected_words.push_back(r);
    end
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    chunk_cmd_t c;
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_cmd(pending_cmds.pop_front());
        n_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds[0];
          s_tdata <= {7'b0, c.chunk_bytes, c.chunk_seq, c.owner_id};
          s_tuser <= c.cmd;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_tvalid <= offer;
    end
  end

  // receiver stall pattern, with one long hold-off after the first 300 accepted commands
  int rx_mode = 0;
  int rx_phase = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && n_accepted >= 300) begin
        hold_done = 1;
        hold_left = 3000;
      end
      if (rx_phase == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_phase = $urandom_range(16, 128);
      end else begin
        rx_phase--;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        default: rdy = ($urandom_range(0, 4) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      m_tready <= rdy;
    end
  end

  // monitor
  always @(posedge clk) begin
    chunk_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_words++;
      if (expected_words.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word %h", m_tdata[63:0]);
      end else begin
        e = expected_words.pop_front();
        if (m_tdata[63:0] !== e.word || m_tdata[67:64] !== e.nbytes
            || m_tlast !== e.last || m_tdata[71:68] !== 4'b0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("word %0d: expected %h/%0d/%b got %h/%0d/%b pad %h", n_words,
                     e.word, e.nbytes, e.last, m_tdata[63:0], m_tdata[67:64], m_tlast,
                     m_tdata[71:68]);
        end
      end
    end
  end

  task automatic add_cmd(input op_kind_t cmd, input logic [63:0] id, input logic [63:0] idx,
                         input logic [16:0] nb);
    chunk_cmd_t c;
    c.cmd = cmd;
    c.owner_id = id;
    c.chunk_seq = idx;
    c.chunk_bytes = nb;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int total;
    int nb;
    int draws;
    // draws before any start produce nothing
    add_cmd(OP_DRAW, '1, '1, '1);
    add_cmd(OP_DRAW, 0, 0, 0);
    // seed wraps past 2^64, short last word
    add_cmd(OP_START, '1, 64'd5, 17'd13);
    repeat (3) add_cmd(OP_DRAW, rand64(), rand64(), 17'h1FFFF);
    // empty chunk
    add_cmd(OP_START, 64'd7, 64'd0, 17'd0);
    add_cmd(OP_DRAW, 0, 0, 0);
    // oversized chunk saturates
    add_cmd(OP_START, 0, 0, 17'h1FFFF);
    repeat (3) add_cmd(OP_DRAW, 0, 0, 0);
    add_cmd(OP_START, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 17'd1);
    repeat (2) add_cmd(OP_DRAW, 0, 0, 0);
    add_cmd(OP_START, 64'd1, 64'd2, 17'd8);
    repeat (2) add_cmd(OP_DRAW, 0, 0, 0);
    add_cmd(OP_START, 64'd3, 64'd4, 17'd65536);
    repeat (2) add_cmd(OP_DRAW, 0, 0, 0);
    total = pending_cmds.size();
    while (total < N_ITEMS) begin
      case ($urandom_range(0, 19))
        0: nb = $urandom_range(0, 17'h1FFFF);
        1: nb = 0;
        default: nb = $urandom_range(1, 160);
      endcase
      add_cmd(OP_START, rand64(), rand64(), 17'(nb));
      draws = (nb + 7) / 8;
      if (draws > 60) draws = $urandom_range(1, 60);
      // sometimes cut the chunk short or overdraw it
      case ($urandom_range(0, 5))
        0: draws = $urandom_range(0, draws);
        1: draws = draws + $urandom_range(1, 3);
        default: ;
      endcase
      repeat (draws) add_cmd(OP_DRAW, rand64(), rand64(), 17'($urandom));
      total += draws + 1;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("%0d commands sent, %0d chunk starts, %0d words checked, %0d mismatches",
             n_accepted, n_starts, n_words, n_errors);
    $display("covered wrapped seeds, empty and oversized chunks, short last words, overdraws");
    if (n_errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d words still expected", expected_words.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
